/* hw/rtl/bitmap_first_fit_allocator_core_macros.svh */
// Assertion macros for the bitmap allocator RTL.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BFA_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`define BFA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BFA_ASSERT_NEVER(label, expr)
`define BFA_ASSERT_IMPL(label, ante, cons)
`define BFA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hw/rtl/bfa_pkg.sv */
// Shared types, constants and helpers of the bitmap allocator.
// No dependencies.
package bfa_pkg;

    localparam int MAP_BITS_DEF  = 4096;
    localparam int WORD_BITS_DEF = 64;
    localparam int WORD_MAX      = 64;
    localparam int LSB_W         = 6;
    localparam int POS_W         = 17;
    localparam int IDX_W         = 13;
    localparam int CMD_W         = 3;
    localparam int ALN_W         = 12;
    localparam logic [IDX_W-1:0] SIZE_RESET = 13'd4096;

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND_AREA = 3'd0,
        CMD_SET_RANGE = 3'd1,
        CMD_CLR_RANGE = 3'd2,
        CMD_TEST      = 3'd3,
        CMD_TEST_SET  = 3'd4,
        CMD_TEST_CLR  = 3'd5,
        CMD_NEXT_SET  = 3'd6,
        CMD_NEXT_CLR  = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POST,
        ST_ALIGN,
        ST_CHECK,
        ST_RANGE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             old_bit;
    } res_t;

    function automatic logic [LSB_W-1:0] lsb_index(input logic [WORD_MAX-1:0] v);
        logic [WORD_MAX-1:0] iso;
        logic [LSB_W-1:0]    idx;
        iso = v & (~v + {{(WORD_MAX-1){1'b0}}, 1'b1});
        idx = '0;
        for (int j = 0; j < WORD_MAX; j++)
        begin
            if (iso[j])
            begin
                idx = idx | LSB_W'(j);
            end
        end
        return idx;
    endfunction

endpackage

/* hw/rtl/bfa_channels.sv */
// Valid/ready channel interfaces of the bitmap allocator.
// Depends on bfa_pkg.
interface bfa_req_if import bfa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] start_req;
    logic [IDX_W-1:0] count;
    logic [ALN_W-1:0] area_mask;
    logic [ALN_W-1:0] area_offset;
    modport source (output valid, cmd, start_req, count, area_mask, area_offset,
                    input ready);
    modport sink (input valid, cmd, start_req, count, area_mask, area_offset,
                  output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic             old_bit;
    modport source (output valid, index, old_bit, input ready);
    modport sink (input valid, index, old_bit, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] bitmap_size;
    modport source (output valid, bitmap_size, input ready);
    modport sink (input valid, bitmap_size, output ready);
endinterface

/* hw/rtl/bfa_store.sv */
// Word memory of the allocation bitmap with registered read.
// Per-word valid bits make unwritten words read as zero after reset.
module bfa_store #(
    parameter int WORDS     = 64,
    parameter int WORD_BITS = 64,
    parameter int AW        = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data
);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic                 valid_reg [WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORDS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* hw/rtl/bfa_ctrl.sv */
// Command sequencer: word-per-cycle scans, range read-modify-write and area search.
// Depends on bfa_pkg, bfa_channels and the assertion macro header.
`include "bitmap_first_fit_allocator_core_macros.svh"
module bfa_ctrl import bfa_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int AW        = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bfa_req_if.sink              req,
    input  logic [POS_W-1:0]     size,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  logic [WORD_BITS-1:0] rd_data,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [WORD_BITS-1:0] wr_data
);

    localparam int OB = $clog2(WORD_BITS);
    localparam logic [POS_W-1:0] WB = POS_W'(WORD_BITS);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [POS_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  amask_reg, amask_next;
    logic [POS_W-1:0]  aoff_reg, aoff_next;
    logic [POS_W-1:0]  from_reg, from_next;
    logic [POS_W-1:0]  lim_reg, lim_next;
    logic [POS_W-1:0]  rd_w_reg, rd_w_next;
    logic [POS_W-1:0]  data_w_reg, data_w_next;
    logic [POS_W-1:0]  r_reg, r_next;
    logic [POS_W-1:0]  s_reg, s_next;
    logic [POS_W-1:0]  t_reg, t_next;
    logic [POS_W-1:0]  res_idx_reg, res_idx_next;
    logic              rvalid_reg, rvalid_next;
    logic              want_reg, want_next;
    logic              phase_reg, phase_next;
    logic              wen_reg, wen_next;
    logic              set_reg, set_next;
    logic              old_reg, old_next;

    logic [POS_W-1:0]     base, lo, hi, pos, st_in, sum_in, s_chk;
    logic [WORD_BITS-1:0] ones, ge_mask, lt_mask, wmask, cand;
    logic                 found, last, issue;
    logic                 go_scan, go_want, go_phase, fin;
    logic [POS_W-1:0]     go_from, fin_idx;
    cmd_t                 cmd_in;

    assign ones    = '1;
    assign base    = data_w_reg << OB;
    assign lo      = (from_reg > base) ? (from_reg - base) : '0;
    assign hi      = lim_reg - base;
    assign ge_mask = ones << lo[OB-1:0];
    assign lt_mask = (hi >= WB) ? ones : ~(ones << hi[OB-1:0]);
    assign wmask   = ge_mask & lt_mask;
    assign cand    = (want_reg ? rd_data : ~rd_data) & wmask;
    assign found   = |cand;
    assign pos     = base + POS_W'(lsb_index(WORD_MAX'(cand)));
    assign last    = (base + WB) >= lim_reg;
    assign issue   = ((rd_w_reg << OB) < lim_reg) && (from_reg < lim_reg);
    assign st_in   = POS_W'(req.start_req);
    assign sum_in  = st_in + POS_W'(req.count);
    assign s_chk   = t_reg - aoff_reg;
    assign cmd_in  = cmd_t'(req.cmd);

    assign rd_addr = rd_w_reg[AW-1:0];
    assign wr_addr = data_w_reg[AW-1:0];
    assign res.index   = res_idx_reg[IDX_W-1:0];
    assign res.old_bit = old_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cnt_reg     <= cnt_next;
        amask_reg   <= amask_next;
        aoff_reg    <= aoff_next;
        from_reg    <= from_next;
        lim_reg     <= lim_next;
        rd_w_reg    <= rd_w_next;
        data_w_reg  <= data_w_next;
        r_reg       <= r_next;
        s_reg       <= s_next;
        t_reg       <= t_next;
        res_idx_reg <= res_idx_next;
        want_reg    <= want_next;
        phase_reg   <= phase_next;
        wen_reg     <= wen_next;
        set_reg     <= set_next;
        old_reg     <= old_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        amask_next   = amask_reg;
        aoff_next    = aoff_reg;
        from_next    = from_reg;
        lim_next     = lim_reg;
        rd_w_next    = rd_w_reg;
        data_w_next  = data_w_reg;
        r_next       = r_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        res_idx_next = res_idx_reg;
        want_next    = want_reg;
        phase_next   = phase_reg;
        wen_next     = wen_reg;
        set_next     = set_reg;
        old_next     = old_reg;
        rvalid_next  = 1'b0;
        req.ready    = 1'b0;
        res_valid    = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_data      = set_reg ? (rd_data | wmask) : (rd_data & ~wmask);
        go_scan      = 1'b0;
        go_from      = '0;
        go_want      = 1'b0;
        go_phase     = 1'b0;
        fin          = 1'b0;
        fin_idx      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cmd_next   = cmd_in;
                    cnt_next   = POS_W'(req.count);
                    amask_next = POS_W'(req.area_mask);
                    aoff_next  = POS_W'(req.area_offset);
                    old_next   = 1'b0;
                    from_next  = st_in;
                    rd_w_next  = st_in >> OB;
                    unique case (cmd_in)
                        CMD_FIND_AREA:
                        begin
                            if (sum_in > size)
                            begin
                                fin     = 1'b1;
                                fin_idx = size;
                            end
                            else
                            begin
                                go_scan = 1'b1;
                                go_from = st_in;
                            end
                        end
                        CMD_SET_RANGE, CMD_CLR_RANGE:
                        begin
                            lim_next   = (sum_in < size) ? sum_in : size;
                            wen_next   = 1'b1;
                            set_next   = (cmd_in == CMD_SET_RANGE);
                            state_next = ST_RANGE;
                        end
                        CMD_TEST, CMD_TEST_SET, CMD_TEST_CLR:
                        begin
                            lim_next   = ((st_in + 1'b1) < size) ? (st_in + 1'b1) : size;
                            wen_next   = (cmd_in != CMD_TEST);
                            set_next   = (cmd_in == CMD_TEST_SET);
                            state_next = ST_RANGE;
                        end
                        CMD_NEXT_SET, CMD_NEXT_CLR:
                        begin
                            go_scan = 1'b1;
                            go_from = st_in;
                            go_want = (cmd_in == CMD_NEXT_SET);
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_en = issue;
                if (issue)
                begin
                    rd_w_next   = rd_w_reg + 1'b1;
                    data_w_next = rd_w_reg;
                end
                rvalid_next = issue;
                if (from_reg >= lim_reg)
                begin
                    r_next      = lim_reg;
                    rvalid_next = 1'b0;
                    state_next  = ST_POST;
                end
                else if (rvalid_reg && (found || last))
                begin
                    r_next      = found ? pos : lim_reg;
                    rvalid_next = 1'b0;
                    state_next  = ST_POST;
                end
            end
            ST_RANGE:
            begin
                rd_en = issue;
                if (issue)
                begin
                    rd_w_next   = rd_w_reg + 1'b1;
                    data_w_next = rd_w_reg;
                end
                rvalid_next = issue;
                if (from_reg >= lim_reg)
                begin
                    fin         = 1'b1;
                    rvalid_next = 1'b0;
                end
                else if (rvalid_reg)
                begin
                    wr_en = wen_reg;
                    if (cmd_reg == CMD_TEST || cmd_reg == CMD_TEST_SET
                        || cmd_reg == CMD_TEST_CLR)
                    begin
                        old_next = |(rd_data & wmask);
                    end
                    if (last)
                    begin
                        fin         = 1'b1;
                        rvalid_next = 1'b0;
                    end
                end
            end
            ST_POST:
            begin
                if (cmd_reg != CMD_FIND_AREA)
                begin
                    fin     = 1'b1;
                    fin_idx = r_reg;
                end
                else if (!phase_reg)
                begin
                    state_next = ST_ALIGN;
                end
                else if ((r_reg - s_reg) >= cnt_reg)
                begin
                    fin     = 1'b1;
                    fin_idx = s_reg;
                end
                else if ((r_reg + 1'b1 + cnt_reg) <= size)
                begin
                    go_scan = 1'b1;
                    go_from = r_reg + 1'b1;
                end
                else
                begin
                    fin     = 1'b1;
                    fin_idx = size;
                end
            end
            ST_ALIGN:
            begin
                t_next     = (r_reg + aoff_reg + amask_reg) & ~amask_reg;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if ((s_chk + cnt_reg) > size)
                begin
                    fin     = 1'b1;
                    fin_idx = size;
                end
                else
                begin
                    s_next   = s_chk;
                    go_scan  = 1'b1;
                    go_from  = s_chk;
                    go_want  = 1'b1;
                    go_phase = 1'b1;
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (go_scan)
        begin
            from_next   = go_from;
            want_next   = go_want;
            phase_next  = go_phase;
            lim_next    = size;
            rd_w_next   = go_from >> OB;
            rvalid_next = 1'b0;
            state_next  = ST_SCAN;
        end
        if (fin)
        begin
            res_idx_next = fin_idx;
            state_next   = ST_DONE;
        end
    end

    `BFA_ASSERT_NEVER(a_rw_same_word, rd_en && wr_en && (rd_addr == wr_addr))
    `BFA_ASSERT_IMPL(a_result_in_map, state_reg == ST_DONE, res_idx_reg <= size)
    `BFA_ASSERT_NEXT(a_busy_after_transfer, req.valid && req.ready, state_reg != ST_IDLE)

endmodule

/* hw/rtl/bitmap_first_fit_allocator_core.sv */
// Bitmap first-fit allocator top level: size register, sequencer, word memory, result register.
// Depends on bfa_pkg, bfa_channels, bfa_store and bfa_ctrl.
//
// Usage:
//   req  carries one command per transfer (find area, set/clear range, test,
//        test-and-set, test-and-clear, next set bit, next clear bit).
//   rsp  returns exactly one result per command: index and old_bit.
//   cfg  writes bitmap_size; write it only while no command is in flight.
// One command is worked on at a time. Scans and range commands read one memory
// word per cycle through the single read port; range writes write back the
// previous word in the same cycle. An area search repeats a clear-bit scan,
// a step, align and check pass, and a set-bit scan per candidate, so its
// latency grows with the number of candidates.
// The result sits in an output register; the next command is taken while it
// waits, and the sequencer holds its own result until that register frees up
// when rsp stalls.
// Reset clears the map through per-word valid bits at once and sets
// bitmap_size to 4096; no clearing pass is needed.
module bitmap_first_fit_allocator_core import bfa_pkg::*; #(
    parameter int MAP_BITS  = MAP_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    bfa_req_if.sink  req,
    bfa_rsp_if.source rsp,
    bfa_cfg_if.sink  cfg
);

    localparam int WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [POS_W-1:0] MAP_LIM = POS_W'(MAP_BITS);

    logic [IDX_W-1:0]     size_reg;
    logic [POS_W-1:0]     size_eff;
    logic                 out_valid_reg;
    res_t                 out_reg;
    logic                 res_valid, res_ready;
    res_t                 res;
    logic                 rd_en, wr_en;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [WORD_BITS-1:0] rd_data, wr_data;

    assign cfg.ready = 1'b1;
    assign size_eff  = (POS_W'(size_reg) < MAP_LIM) ? POS_W'(size_reg) : MAP_LIM;
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                size_reg <= cfg.bitmap_size;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.index   = out_reg.index;
    assign rsp.old_bit = out_reg.old_bit;

    bfa_ctrl #(
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .size      (size_eff),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    bfa_store #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule
